// File: rtl/core/assert_macros.svh
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge outside reset
`define EDC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// condition in one cycle implies a condition in the next
`define EDC_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/core/edc_pkg.sv
package edc_pkg;

	localparam int DEF_ELEM_BITS = 16;
	localparam int DEF_ACC_BITS = 56;
	localparam int DIST_BITS = 28;
	localparam int OUT_DEPTH = 2;
	localparam int CREDIT_W = $clog2(OUT_DEPTH + 1);

	localparam logic [DIST_BITS-1:0] DIST_MAX = '1;

	typedef struct packed {
		logic valid;
		logic sat;
	} edc_ctl_t;

endpackage

// File: rtl/core/edc_accum.sv
module edc_accum import edc_pkg::*; #(
	parameter int ELEM_BITS = DEF_ELEM_BITS,
	parameter int ACC_BITS = DEF_ACC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_fire,
	input  logic [ELEM_BITS-1:0] coord_a,
	input  logic [ELEM_BITS-1:0] coord_b,
	input  logic                 last_elem,
	output edc_ctl_t             ctl_s3,
	output logic [ACC_BITS-1:0]  sum_s3
);

	localparam int MAG_W = ELEM_BITS + 1;
	localparam int SQ_W = 2 * MAG_W;
	localparam int ADD_W = ((SQ_W > ACC_BITS) ? SQ_W : ACC_BITS) + 1;

	logic [MAG_W-1:0]    diff;
	logic [MAG_W-1:0]    mag;
	logic [MAG_W-1:0]    mag_s1;
	logic                last_s1;
	logic                valid_s1;
	logic [SQ_W-1:0]     sq_s2;
	logic                last_s2;
	logic                valid_s2;
	logic [ACC_BITS-1:0] sum_q;
	logic                ovf_q;
	logic [ADD_W-1:0]    total;
	logic                over;
	logic [ACC_BITS-1:0] sum_nx;
	logic                ovf_nx;

	assign diff = {coord_a[ELEM_BITS-1], coord_a} - {coord_b[ELEM_BITS-1], coord_b};
	assign mag = diff[MAG_W-1] ? (-diff) : diff;

	// saturating add of the square into the running sum
	assign total = ADD_W'(sum_q) + ADD_W'(sq_s2);
	assign over = |total[ADD_W-1:ACC_BITS];
	assign sum_nx = over ? '1 : total[ACC_BITS-1:0];
	assign ovf_nx = ovf_q | over;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sum_q <= '0;
			ovf_q <= 1'b0;
			ctl_s3 <= '0;
		end else begin
			valid_s1 <= in_fire;
			valid_s2 <= valid_s1;
			ctl_s3.valid <= valid_s2 && last_s2;
			ctl_s3.sat <= ovf_nx;
			if (valid_s2) begin
				if (last_s2) begin
					sum_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					sum_q <= sum_nx;
					ovf_q <= ovf_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mag_s1 <= mag;
			last_s1 <= last_elem;
		end
		sq_s2 <= SQ_W'(mag_s1) * SQ_W'(mag_s1);
		last_s2 <= last_s1;
		sum_s3 <= sum_nx;
	end

endmodule

// File: rtl/core/edc_cell.sv
module edc_cell import edc_pkg::*; #(
	parameter int ROOT_BITS = (DEF_ACC_BITS + 1) / 2
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  edc_ctl_t               ctl_in,
	input  logic [2*ROOT_BITS-1:0] x_in,
	input  logic [ROOT_BITS:0]     rem_in,
	input  logic [ROOT_BITS-1:0]   root_in,
	output edc_ctl_t               ctl_out,
	output logic [2*ROOT_BITS-1:0] x_out,
	output logic [ROOT_BITS:0]     rem_out,
	output logic [ROOT_BITS-1:0]   root_out
);

	localparam int X_W = 2 * ROOT_BITS;
	localparam int REM_W = ROOT_BITS + 1;
	localparam int TRY_W = REM_W + 2;

	logic [TRY_W-1:0] rem_sh;
	logic [TRY_W-1:0] trial;
	logic [TRY_W-1:0] rem_sub;
	logic             fit;

	// one root bit per cell: bring down two bits, try 4*root+1
	assign rem_sh = {rem_in, x_in[X_W-1 -: 2]};
	assign trial = TRY_W'({root_in, 2'b01});
	assign rem_sub = rem_sh - trial;
	assign fit = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		x_out <= x_in << 2;
		rem_out <= fit ? rem_sub[REM_W-1:0] : rem_sh[REM_W-1:0];
		root_out <= {root_in[ROOT_BITS-2:0], fit};
	end

endmodule

// File: rtl/core/edc_sqrt.sv
module edc_sqrt import edc_pkg::*; #(
	parameter int ACC_BITS = DEF_ACC_BITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  edc_ctl_t                        ctl_in,
	input  logic [ACC_BITS-1:0]             sum_in,
	output edc_ctl_t                        ctl_out,
	output logic [(ACC_BITS + 1) / 2 - 1:0] root_out
);

	localparam int ROOT_BITS = (ACC_BITS + 1) / 2;
	localparam int X_W = 2 * ROOT_BITS;
	localparam int REM_W = ROOT_BITS + 1;

	edc_ctl_t             ctl_c  [ROOT_BITS+1];
	logic [X_W-1:0]       x_c    [ROOT_BITS+1];
	logic [REM_W-1:0]     rem_c  [ROOT_BITS+1];
	logic [ROOT_BITS-1:0] root_c [ROOT_BITS+1];

	assign ctl_c[0] = ctl_in;
	assign x_c[0] = X_W'(sum_in);
	assign rem_c[0] = '0;
	assign root_c[0] = '0;

	for (genvar i = 0; i < ROOT_BITS; i++) begin : g_cell
		edc_cell #(
			.ROOT_BITS(ROOT_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (ctl_c[i]),
			.x_in    (x_c[i]),
			.rem_in  (rem_c[i]),
			.root_in (root_c[i]),
			.ctl_out (ctl_c[i+1]),
			.x_out   (x_c[i+1]),
			.rem_out (rem_c[i+1]),
			.root_out(root_c[i+1])
		);
	end

	assign ctl_out = ctl_c[ROOT_BITS];
	assign root_out = root_c[ROOT_BITS];

endmodule

// File: rtl/core/edc_outbuf.sv
module edc_outbuf import edc_pkg::*; #(
	parameter int ROOT_BITS = (DEF_ACC_BITS + 1) / 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  edc_ctl_t             ctl_in,
	input  logic [ROOT_BITS-1:0] root_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DIST_BITS-1:0] distance,
	output logic                 sum_saturated
);

	localparam int EXT_W = (ROOT_BITS > DIST_BITS) ? ROOT_BITS : DIST_BITS;

	logic [EXT_W-1:0]     root_ext;
	logic                 big;
	logic [DIST_BITS-1:0] dist_in;
	logic                 sat_in;
	logic                 out_valid_q;
	logic                 hold_valid_q;
	logic [DIST_BITS-1:0] dist_q;
	logic                 sat_q;
	logic [DIST_BITS-1:0] hold_dist_q;
	logic                 hold_sat_q;
	logic                 take;
	logic                 out_free;

	// clamp roots that do not fit the distance field
	assign root_ext = EXT_W'(root_in);
	assign big = (root_ext > EXT_W'(DIST_MAX));
	assign dist_in = big ? DIST_MAX : root_ext[DIST_BITS-1:0];
	assign sat_in = ctl_in.sat | big;

	assign take = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (out_free) begin
			if (hold_valid_q) begin
				out_valid_q <= 1'b1;
				hold_valid_q <= ctl_in.valid;
			end else begin
				out_valid_q <= ctl_in.valid;
			end
		end else if (ctl_in.valid) begin
			hold_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (hold_valid_q) begin
				dist_q <= hold_dist_q;
				sat_q <= hold_sat_q;
				hold_dist_q <= dist_in;
				hold_sat_q <= sat_in;
			end else begin
				dist_q <= dist_in;
				sat_q <= sat_in;
			end
		end else if (ctl_in.valid) begin
			hold_dist_q <= dist_in;
			hold_sat_q <= sat_in;
		end
	end

	assign out_valid = out_valid_q;
	assign distance = dist_q;
	assign sum_saturated = sat_q;

endmodule

// File: rtl/core/euclidean_distance.sv
// a vector's result shows on out_valid after its last word has passed the accumulator stages s1,
// s2 and s3, the square root chain of one cell per root bit, and the output buffer
// throughput: one word per cycle while in_stall is low; at most two vectors' results may be
// outstanding, and in_stall holds the input until the output side takes one
// reset: arst_n clears the running sum, the saturation flag and all valid bits
module euclidean_distance import edc_pkg::*; #(
	parameter int ELEM_BITS = DEF_ELEM_BITS,
	parameter int ACC_BITS = DEF_ACC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [ELEM_BITS-1:0] coord_a,
	input  logic [ELEM_BITS-1:0] coord_b,
	input  logic                 last_elem,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [DIST_BITS-1:0] distance,
	output logic                 sum_saturated
);

	localparam int ROOT_BITS = (ACC_BITS + 1) / 2;

	logic                 in_fire;
	logic                 out_fire;
	logic                 last_fire;
	logic [CREDIT_W-1:0]  credit_q;
	edc_ctl_t             ctl_s3;
	logic [ACC_BITS-1:0]  sum_s3;
	edc_ctl_t             sqrt_ctl;
	logic [ROOT_BITS-1:0] sqrt_root;

	assign in_fire = in_valid && !in_stall;
	assign out_fire = out_valid && !out_stall;
	assign last_fire = in_fire && last_elem;

	// results in flight never exceed the output buffer
	assign in_stall = (credit_q == CREDIT_W'(OUT_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			credit_q <= credit_q + CREDIT_W'(last_fire) - CREDIT_W'(out_fire);
		end
	end

	edc_accum #(
		.ELEM_BITS(ELEM_BITS),
		.ACC_BITS (ACC_BITS)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.coord_a  (coord_a),
		.coord_b  (coord_b),
		.last_elem(last_elem),
		.ctl_s3   (ctl_s3),
		.sum_s3   (sum_s3)
	);

	edc_sqrt #(
		.ACC_BITS(ACC_BITS)
	) u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s3),
		.sum_in  (sum_s3),
		.ctl_out (sqrt_ctl),
		.root_out(sqrt_root)
	);

	edc_outbuf #(
		.ROOT_BITS(ROOT_BITS)
	) u_outbuf (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_in       (sqrt_ctl),
		.root_in      (sqrt_root),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.distance     (distance),
		.sum_saturated(sum_saturated)
	);

endmodule

// File: rtl/core/edc_checker.sv
`include "assert_macros.svh"

module edc_checker import edc_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_stall,
	input logic                 last_elem,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [DIST_BITS-1:0] distance,
	input logic                 sum_saturated
);

	logic [CREDIT_W-1:0] pend_q;

	// last words taken minus result words delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + CREDIT_W'(in_valid && !in_stall && last_elem)
				- CREDIT_W'(out_valid && !out_stall);
		end
	end

	`EDC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result word dropped while stalled")
	`EDC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(distance) && $stable(sum_saturated), "stalled result word changed")
	`EDC_ASSERT(a_no_orphan, clk, arst_n, out_valid |-> pend_q != '0, "result word without a last word")
	`EDC_ASSERT(a_stall_full, clk, arst_n, in_stall |-> pend_q == CREDIT_W'(OUT_DEPTH), "input stalled with room for results")

endmodule

bind euclidean_distance edc_checker u_edc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.last_elem    (last_elem),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.distance     (distance),
	.sum_saturated(sum_saturated)
);

// File: bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import edc_pkg::*;

	localparam int ELEM_W = DEF_ELEM_BITS;
	localparam int ACC_W = DEF_ACC_BITS;
	localparam logic [63:0] SUM_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - ACC_W);
	localparam int SETTLE_CYCLES = (ACC_W + 1) / 2 + 12;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_WORDS = 1500;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PLAN_ROWS = 21;

	typedef struct packed {
		logic [DIST_BITS-1:0] distance;
		logic                 sat;
	} dist_word_t;

	typedef struct packed {
		logic [ELEM_W-1:0] a;
		logic [ELEM_W-1:0] b;
		logic              last;
		logic              known;
		dist_word_t        want;
	} plan_row_t;

	// known rows carry their result, the rest go through the predictor
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		'{16'h0000, 16'h0000, 1'b1, 1'b1, '{28'd0, 1'b0}},
		'{16'h7FFF, 16'h8000, 1'b1, 1'b1, '{28'd65535, 1'b0}},
		'{16'h8000, 16'h7FFF, 1'b1, 1'b1, '{28'd65535, 1'b0}},
		'{16'h0001, 16'h0000, 1'b1, 1'b1, '{28'd1, 1'b0}},
		'{16'hFFFF, 16'hFFFF, 1'b1, 1'b1, '{28'd0, 1'b0}},
		'{16'h8000, 16'h8000, 1'b1, 1'b1, '{28'd0, 1'b0}},
		'{16'h0003, 16'h0000, 1'b0, 1'b0, '{28'd0, 1'b0}},
		'{16'h0000, 16'hFFFC, 1'b1, 1'b1, '{28'd5, 1'b0}},
		'{16'h7FFF, 16'h8000, 1'b0, 1'b0, '{28'd0, 1'b0}},
		'{16'h7FFF, 16'h8000, 1'b0, 1'b0, '{28'd0, 1'b0}},
		'{16'h7FFF, 16'h8000, 1'b0, 1'b0, '{28'd0, 1'b0}},
		'{16'h7FFF, 16'h8000, 1'b1, 1'b1, '{28'd131070, 1'b0}},
		'{16'h1234, 16'h0FED, 1'b0, 1'b0, '{28'd0, 1'b0}},
		'{16'hEC78, 16'h1B58, 1'b0, 1'b0, '{28'd0, 1'b0}},
		'{16'h3039, 16'hA460, 1'b1, 1'b0, '{28'd0, 1'b0}},
		'{16'h7FFF, 16'h0000, 1'b1, 1'b0, '{28'd0, 1'b0}},
		'{16'h0000, 16'h7FFF, 1'b1, 1'b0, '{28'd0, 1'b0}},
		'{16'h8000, 16'h0000, 1'b0, 1'b0, '{28'd0, 1'b0}},
		'{16'h0000, 16'h8000, 1'b0, 1'b0, '{28'd0, 1'b0}},
		'{16'h5555, 16'hAAAA, 1'b0, 1'b0, '{28'd0, 1'b0}},
		'{16'hAAAA, 16'h5555, 1'b1, 1'b0, '{28'd0, 1'b0}}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic [ELEM_W-1:0] coord_a;
	logic [ELEM_W-1:0] coord_b;
	logic              last_elem;
	logic              out_valid;
	logic              out_stall;
	logic [DIST_BITS-1:0] distance;
	logic              sum_saturated;

	dist_word_t pending_dist_q[$];
	logic [63:0] square_total = '0;
	bit          total_clipped = 1'b0;
	int          mismatches = 0;
	bit          src_steady = 1'b0;
	bit          sink_steady = 1'b0;
	bit          hold_request = 1'b0;

	euclidean_distance dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.coord_a(coord_a),
		.coord_b(coord_b),
		.last_elem(last_elem),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.distance(distance),
		.sum_saturated(sum_saturated)
	);

	always #6 clk = ~clk;

	function automatic logic [63:0] floor_root(input logic [63:0] x);
		logic [63:0] rest;
		logic [63:0] root;
		logic [63:0] probe;
		rest = x;
		root = '0;
		probe = 64'h1 << 62;
		while (probe > rest)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest = rest - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// running sum of squared differences, gives the distance on the last word
	task automatic accumulate_square(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
			input logic last, output bit emits, output dist_word_t result);
		longint signed      diff;
		longint unsigned    mag;
		logic [63:0]        sq;
		logic [63:0]        root;
		diff = longint'($signed(a)) - longint'($signed(b));
		mag = (diff < 0) ? longint'(-diff) : longint'(diff);
		if (mag > 64'hFFFF_FFFF) begin
			square_total = SUM_MAX;
			total_clipped = 1'b1;
		end else begin
			sq = mag * mag;
			if (sq > SUM_MAX - square_total) begin
				square_total = SUM_MAX;
				total_clipped = 1'b1;
			end else begin
				square_total = square_total + sq;
			end
		end
		emits = last;
		result = '0;
		if (last) begin
			root = floor_root(square_total);
			result.sat = total_clipped;
			if (root > 64'(DIST_MAX)) begin
				root = 64'(DIST_MAX);
				result.sat = 1'b1;
			end
			result.distance = root[DIST_BITS-1:0];
			square_total = '0;
			total_clipped = 1'b0;
		end
	endtask

	task automatic send_word(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
			input logic last, input logic known, input dist_word_t want);
		int         gap;
		bit         emits;
		dist_word_t result;
		gap = src_steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		coord_a <= a;
		coord_b <= b;
		last_elem <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		accumulate_square(a, b, last, emits, result);
		if (emits)
			pending_dist_q.insert(pending_dist_q.size(), known ? want : result);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_dist_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [ELEM_W-1:0] pick_coord();
		logic [ELEM_W-1:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
			1: v = 16'($urandom_range(0, 31)) - 16'd16;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	task automatic flag_mismatch(input string why, input dist_word_t want);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch (%s): expected distance %0d sat %0b, got distance %0d sat %0b",
				why, want.distance, want.sat, distance, sum_saturated);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_dist_q.size() == 0)
				flag_mismatch("no word pending", '0);
			else if (distance !== pending_dist_q[0].distance
					|| sum_saturated !== pending_dist_q[0].sat)
				flag_mismatch("wrong field", pending_dist_q.pop_front());
			else
				void'(pending_dist_q.pop_front());
		end
	end

	initial begin : sink
		int hold;
		bit long_done;
		long_done = 1'b0;
		out_stall <= 1'b1;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request && !long_done) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				long_done = 1'b1;
			end
			hold = sink_steady ? 0 : $urandom_range(0, 3);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	initial begin : watchdog
		int cycle_count;
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("[euclidean_distance] ERROR");
		$finish;
	end

	initial begin : stimulus
		int  sent;
		int  phase_end;
		int  len;
		int  k;
		bit  paused;
		bit  hold_done;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		coord_a <= '0;
		coord_b <= '0;
		last_elem <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < PLAN_ROWS; k++)
			send_word(PLAN[k].a, PLAN[k].b, PLAN[k].last, PLAN[k].known, PLAN[k].want);
		drain_results();

		sent = 0;
		paused = 1'b0;
		hold_done = 1'b0;
		while (sent < RANDOM_WORDS) begin
			src_steady = ($urandom_range(0, 3) == 0);
			sink_steady = ($urandom_range(0, 3) == 0);
			phase_end = sent + $urandom_range(40, 150);
			while (sent < phase_end) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 6);
				for (k = 1; k <= len; k++) begin
					send_word(pick_coord(), pick_coord(), k == len, 1'b0, '0);
					sent++;
				end
			end
			// back up the output side with a burst of one-word vectors
			if (!hold_done && sent >= 500) begin
				hold_request = 1'b1;
				src_steady = 1'b1;
				for (k = 0; k < 40; k++) begin
					send_word(pick_coord(), pick_coord(), 1'b1, 1'b0, '0);
					sent++;
				end
				hold_done = 1'b1;
			end
			if (!paused || $urandom_range(0, 3) == 0) begin
				drain_results();
				paused = 1'b1;
			end
		end
		drain_results();

		if (mismatches == 0)
			$display("[euclidean_distance] OK");
		else
			$display("[euclidean_distance] ERROR");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/edc_pkg.sv
rtl/core/edc_accum.sv
rtl/core/edc_cell.sv
rtl/core/edc_sqrt.sv
rtl/core/edc_outbuf.sv
rtl/core/euclidean_distance.sv
rtl/core/edc_checker.sv
bench/tb_top.sv
